// ----- rtl/core/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// Holds the controller state type and the controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPDATE_END,
        ST_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;      // latch the request beat and clear the scan results
        logic scan_issue;  // read key, value and rank of the slot under the index counter
        logic decide;      // resolve hit, victim and target; write key and value on a put
        logic upd_issue;   // read a rank for the rank rewrite sweep
        logic out_load;    // move the result into the output register
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic idx_last;    // index counter is at the last slot
        logic need_update; // the request changes recency ranks
        logic out_free;    // output register can take a result this cycle
    } t_ctl_sts;

endpackage

// ----- rtl/core/lkvc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/lkvc_ctrl.sv -----
// Sequencing state machine for the LRU key/value cache.
// Depends on lkvc_pkg for the state type and the command and status bundles.
`timescale 1ns / 1ps

module lkvc_ctrl import lkvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.idx_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_sts.need_update ? ST_UPDATE : ST_FINISH;
            end
            ST_UPDATE: begin
                if (i_sts.idx_last) begin
                    n_state = ST_UPDATE_END;
                end
            end
            ST_UPDATE_END: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.accept = i_in_valid;
            end
            ST_SCAN: begin
                o_ctl.scan_issue = 1'b1;
            end
            ST_DECIDE: begin
                o_ctl.decide = 1'b1;
            end
            ST_UPDATE: begin
                o_ctl.upd_issue = 1'b1;
            end
            ST_FINISH: begin
                o_ctl.out_load = i_sts.out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/lkvc_dp.sv -----
// Datapath of the LRU key/value cache: slot memories, valid bits, scan and rank rewrite logic.
// Depends on lkvc_pkg and lkvc_ram.
`timescale 1ns / 1ps

module lkvc_dp import lkvc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl_cmd                  i_ctl,
    output t_ctl_sts                  o_sts,
    input  logic                      i_req_cmd,
    input  logic signed [KEY_W-1:0]   i_req_key,
    input  logic signed [VALUE_W-1:0] i_req_value,
    input  logic                      i_cfg_we,
    input  logic [CAP_W-1:0]          i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_hit,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic                      o_evicted,
    output logic signed [KEY_W-1:0]   o_evicted_key
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Configuration and occupancy.
    logic [CAP_W-1:0]   r_cap;
    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]      r_occ;

    // Sweep control.
    logic [IW-1:0] r_idx;
    logic          r_rd_scan;
    logic          r_rd_upd;
    logic [IW-1:0] r_rd_idx;

    // Request under way.
    logic               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;

    // Scan results.
    logic               r_hit_f;
    logic [IW-1:0]      r_hit_idx;
    logic [VALUE_W-1:0] r_hit_val;
    logic [IW-1:0]      r_old_rank;
    logic [IW-1:0]      r_vic_idx;
    logic [KEY_W-1:0]   r_vic_key;
    logic               r_free_f;
    logic [IW-1:0]      r_free_idx;

    // Decision.
    logic          r_ins;
    logic [IW-1:0] r_tgt;
    logic          r_ev;

    // Output register.
    logic               r_out_valid;
    logic               r_out_hit;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ev;
    logic [KEY_W-1:0]   r_out_ev_key;

    logic [KEY_W-1:0]   key_rd;
    logic [VALUE_W-1:0] val_rd;
    logic [IW-1:0]      rank_rd;

    logic               slot_valid;
    logic               rank_is_lru;
    logic               is_put;
    logic [CW-1:0]      cap_x;
    logic [CW-1:0]      eff_cap;
    logic               full;
    logic               dec_evict;
    logic [IW-1:0]      dec_tgt;
    logic [ENTRIES-1:0] vic_mask;
    logic [ENTRIES-1:0] tgt_mask;
    logic               upd_wr;
    logic [IW-1:0]      upd_rank;
    logic               out_free;

    // ---------------------------------------------------------------------
    // Slot memories; all three are read at the sweep index.
    // ---------------------------------------------------------------------
    lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.decide && is_put && !r_hit_f),
        .i_wr_addr (dec_tgt),
        .i_wr_data (r_key),
        .i_rd_addr (r_idx),
        .o_rd_data (key_rd)
    );

    lkvc_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.decide && is_put),
        .i_wr_addr (dec_tgt),
        .i_wr_data (r_value),
        .i_rd_addr (r_idx),
        .o_rd_data (val_rd)
    );

    lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (upd_wr),
        .i_wr_addr (r_rd_idx),
        .i_wr_data (upd_rank),
        .i_rd_addr (r_idx),
        .o_rd_data (rank_rd)
    );

    // ---------------------------------------------------------------------
    // Combinational decode.
    // ---------------------------------------------------------------------
    assign slot_valid  = r_valid[r_rd_idx];
    // Valid ranks are always a permutation of 0 .. occupancy-1.
    assign rank_is_lru = (OW'(rank_rd) == (r_occ - OW'(1)));
    assign is_put      = (r_cmd == CMD_PUT);

    always_comb begin
        cap_x = CW'(r_cap);
        if (cap_x == CW'(0)) begin
            eff_cap = CW'(1);
        end else if (cap_x > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    assign full      = (CW'(r_occ) >= eff_cap);
    assign dec_evict = is_put && !r_hit_f && full;

    // The freed victim competes with any earlier empty slot: lowest index wins.
    always_comb begin
        if (r_hit_f) begin
            dec_tgt = r_hit_idx;
        end else if (dec_evict) begin
            dec_tgt = (r_free_f && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;
        end else begin
            dec_tgt = r_free_idx;
        end
    end

    // Valid bits cleared by an eviction and set by an insert; setting wins.
    always_comb begin
        vic_mask = '0;
        tgt_mask = '0;
        if (dec_evict) begin
            vic_mask[r_vic_idx] = 1'b1;
        end
        tgt_mask[dec_tgt] = 1'b1;
    end

    assign upd_wr   = r_rd_upd && ((r_rd_idx == r_tgt) ||
                      (slot_valid && (r_ins || (rank_rd < r_old_rank))));
    assign upd_rank = (r_rd_idx == r_tgt) ? '0 : (rank_rd + IW'(1));

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.idx_last    = (r_idx == LAST_IDX);
    assign o_sts.need_update = r_hit_f || is_put;
    assign o_sts.out_free    = out_free;

    // ---------------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_rd_scan   <= 1'b0;
            r_rd_upd    <= 1'b0;
            r_hit_f     <= 1'b0;
            r_free_f    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end

            if (i_ctl.accept || i_ctl.decide) begin
                r_idx <= '0;
            end else if (i_ctl.scan_issue || i_ctl.upd_issue) begin
                r_idx <= r_idx + IW'(1);
            end
            r_rd_scan <= i_ctl.scan_issue;
            r_rd_upd  <= i_ctl.upd_issue;

            if (i_ctl.accept) begin
                r_hit_f  <= 1'b0;
                r_free_f <= 1'b0;
            end else if (r_rd_scan) begin
                if (slot_valid && (key_rd == r_key)) begin
                    r_hit_f <= 1'b1;
                end
                if (!slot_valid) begin
                    r_free_f <= 1'b1;
                end
            end

            if (i_ctl.decide && is_put && !r_hit_f) begin
                if (!dec_evict) begin
                    r_occ <= r_occ + OW'(1);
                end
                r_valid <= (r_valid & ~vic_mask) | tgt_mask;
            end

            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;

        if (i_ctl.accept) begin
            r_cmd   <= i_req_cmd;
            r_key   <= i_req_key;
            r_value <= i_req_value;
        end

        if (r_rd_scan) begin
            if (slot_valid && (key_rd == r_key) && !r_hit_f) begin
                r_hit_idx  <= r_rd_idx;
                r_hit_val  <= val_rd;
                r_old_rank <= rank_rd;
            end
            if (slot_valid && rank_is_lru) begin
                r_vic_idx <= r_rd_idx;
                r_vic_key <= key_rd;
            end
            if (!slot_valid && !r_free_f) begin
                r_free_idx <= r_rd_idx;
            end
        end

        if (i_ctl.decide) begin
            r_ins <= is_put && !r_hit_f;
            r_tgt <= dec_tgt;
            r_ev  <= dec_evict;
        end

        if (i_ctl.out_load) begin
            r_out_hit    <= r_hit_f;
            r_out_value  <= (!is_put && r_hit_f) ? r_hit_val : '1;
            r_out_ev     <= r_ev;
            r_out_ev_key <= r_ev ? r_vic_key : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_value;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_ev_key;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count disagrees with the valid bits");

    a_insert_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.decide && is_put && !r_hit_f) |-> (full || r_free_f))
        else $error("insert found neither a free slot nor a victim");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.decide && r_hit_f) |-> r_valid[r_hit_idx])
        else $error("hit recorded on an empty slot");

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// A result is presented after the search sweep, the decision and the rank rewrite sweep for a
// hit or a put, and after the search sweep and the decision alone for a get that misses.
// Requests are handled one at a time, and each slot is read in turn through the
// single read port of the slot memories, which is swept once to search and once to rerank.
// Reset (i_rst_n, synchronous, active low) empties the store and sets the capacity to 16.
`timescale 1ns / 1ps

// Fully associative key/value store with least-recently-used replacement.
//
// The keys, values and recency ranks of the slots live in three small RAMs. Each request
// first sweeps every slot: the key comparison finds a hit, the slot whose rank equals
// occupancy-1 is the least recent one, and the lowest empty slot is remembered. The decision
// state then writes a put's key and value, retires any victim and sets the target valid.
// A second sweep rewrites the ranks: on an insert every other valid rank moves up by one,
// on a hit only the ranks below the touched entry move, and the target takes rank zero.
// A get that misses leaves the ranks alone and skips the second sweep.
//
// The valid bits are flip-flops cleared by reset, so the RAMs need no clearing pass and the
// block takes requests straight after reset. The result sits in an output register, so a
// new request beat is accepted while an earlier result still waits to be taken.
// The capacity register is written whenever a beat arrives, with o_cfg_ready held high. It
// is sampled in the decision cycle of each request, so it should only be written while no
// request is in flight.
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic signed [KEY_W-1:0]   i_lookup_key,
    input  logic signed [VALUE_W-1:0] i_put_value,

    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_hit,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic                      o_evicted,
    output logic signed [KEY_W-1:0]   o_evicted_key,

    // Capacity register write channel.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CAP_W-1:0]          i_cfg_data
);

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    // The capacity register is a plain flop, so a write beat always completes.
    assign o_cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    lkvc_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_req_cmd     (i_cmd),
        .i_req_key     (i_lookup_key),
        .i_req_value   (i_put_value),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule
